FILE: src/xml_entity_decoder_top_assert.svh
// Assertion macros used by the checker in xed_checker.sv.
`ifndef XML_ENTITY_DECODER_TOP_ASSERT_SVH
`define XML_ENTITY_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XED_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xed: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define XED_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xed: next-cycle check failed");

`endif

FILE: src/xed_pkg.sv
package xed_pkg;

   // What one input byte does to the held candidate
   typedef enum logic [2:0] {
      KIND_COPY,   // no candidate, plain byte
      KIND_OPEN,   // no candidate, '&' opens one
      KIND_HOLD,   // candidate grows
      KIND_DONE,   // candidate resolves to one byte
      KIND_FAIL    // candidate breaks or grows too long
   } kind_type;

   // Source of the output register
   typedef enum logic [1:0] {
      SRC_IN,
      SRC_RES,
      SRC_MEM,
      SRC_TAIL
   } src_type;

   // Controller to datapath
   typedef struct packed {
      logic    step;          // apply the decision for the input byte
      logic    save_tail;     // keep the breaking byte for later
      logic    rd_first;      // read held entry 0
      logic    rd_next;       // read the following held entry
      logic    out_load;      // load the output register
      src_type out_src;
      logic    out_run_last;
      logic    out_str_last;
      logic    clear;         // drop the candidate
      logic    reopen;        // drop the candidate and open a new one with '&'
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     in_last;
      logic     in_amp;
      logic     tail_last;
      logic     more;         // further held entries follow the one read
      logic     out_free;     // output register can take an item this cycle
   } status_type;

endpackage

FILE: src/xed_datapath.sv
module xed_datapath import xed_pkg::*; #(
   parameter int MAX_PENDING = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   localparam int CW = $clog2(MAX_PENDING + 1);
   localparam int AW = $clog2(MAX_PENDING);
   localparam logic [CW-1:0] HELD_MAX = CW'(MAX_PENDING);

   localparam int NUM_ENT = 5;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QMARK = 8'h3F;

   // Named entities, padded with zeros to eight columns
   localparam logic [7:0] ENT_TEXT [NUM_ENT][8] = '{
      '{"&", "a", "m", "p", ";", 8'h00, 8'h00, 8'h00},
      '{"&", "l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"&", "g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"&", "q", "u", "o", "t", ";", 8'h00, 8'h00},
      '{"&", "a", "p", "o", "s", ";", 8'h00, 8'h00}
   };
   localparam int ENT_LEN [NUM_ENT] = '{5, 4, 4, 6, 6};
   localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_AMP,
      PH_NAMED,
      PH_HASH,
      PH_NUM_WS,
      PH_NUM_SIGN,
      PH_NUM_ZERO,
      PH_NUM_ZX,
      PH_NUM_DIG
   } phase_type;

   // Candidate state
   phase_type            phase_ff, phase_in;
   logic [CW-1:0]        count_ff;
   logic [6:0]           value_ff, value_in;
   logic                 hex_ff, hex_in;
   logic                 neg_ff, neg_in;
   logic                 over_ff, over_in;
   logic [NUM_ENT-1:0]   mask_ff, mask_in;

   // Held bytes and flush read port
   logic [7:0]           held_mem [MAX_PENDING];
   logic [7:0]           rd_data_ff;
   logic [AW-1:0]        ptr_ff;
   logic [AW-1:0]        ptr_nx;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic [7:0]           wr_data;
   logic                 wr_en;

   logic [7:0]           tail_byte_ff;
   logic                 tail_last_ff;

   logic                 out_valid_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_run_last_ff;
   logic                 out_str_last_ff;
   logic [7:0]           out_byte_in;
   logic                 out_free;

   // Decoding of the input byte
   logic [7:0]           b;
   logic                 is_x;
   logic                 is_ws;
   logic                 dig_ok;
   logic [3:0]           dig_val;
   logic [10:0]          acc_sum;
   logic                 acc_over;
   logic [6:0]           acc_val;
   logic [7:0]           num_res;
   logic [NUM_ENT-1:0]   ent_hit;
   logic [NUM_ENT-1:0]   ent_end;
   logic [7:0]           ent_res;
   kind_type             kind;
   logic [7:0]           res_byte;

   assign b     = req_tdata;
   assign is_x  = (b == "x") || (b == "X");
   assign is_ws = (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));

   // Digit value; letters count only in hex
   always_comb begin
      dig_ok  = 1'b0;
      dig_val = 4'd0;
      if ((b >= "0") && (b <= "9")) begin
         dig_ok  = 1'b1;
         dig_val = 4'(b - "0");
      end else if (hex_ff && (b >= "a") && (b <= "f")) begin
         dig_ok  = 1'b1;
         dig_val = 4'(b - "a" + 8'd10);
      end else if (hex_ff && (b >= "A") && (b <= "F")) begin
         dig_ok  = 1'b1;
         dig_val = 4'(b - "A" + 8'd10);
      end
   end

   // value * base + digit, saturating at 127
   always_comb begin
      if (hex_ff) begin
         acc_sum = {value_ff, 4'b0000} + 11'(dig_val);
      end else begin
         acc_sum = 11'({value_ff, 3'b000}) + 11'({value_ff, 1'b0}) + 11'(dig_val);
      end
      acc_over = (acc_sum > 11'd127);
      acc_val  = acc_over ? 7'd127 : acc_sum[6:0];
   end

   assign num_res = (!neg_ff && !over_ff && (value_ff != 7'd0)) ? {1'b0, value_ff} : CH_QMARK;

   // Named entity match at the current position
   always_comb begin
      ent_res = CH_QMARK;
      for (int e = 0; e < NUM_ENT; e++) begin
         ent_hit[e] = mask_ff[e] && (count_ff < CW'(ENT_LEN[e]))
                      && (ENT_TEXT[e][count_ff[2:0]] == b);
         ent_end[e] = ent_hit[e] && (count_ff == CW'(ENT_LEN[e] - 1));
         if (ent_end[e]) begin
            ent_res = ENT_CHAR[e];
         end
      end
   end

   // Step decision for the input byte
   always_comb begin
      kind     = KIND_FAIL;
      phase_in = phase_ff;
      value_in = value_ff;
      hex_in   = hex_ff;
      neg_in   = neg_ff;
      over_in  = over_ff;
      mask_in  = mask_ff;
      res_byte = b;
      if (phase_ff == PH_IDLE) begin
         if (b == CH_AMP) begin
            kind     = KIND_OPEN;
            phase_in = PH_AMP;
         end else begin
            kind = KIND_COPY;
         end
      end else if (count_ff >= HELD_MAX) begin
         kind = KIND_FAIL;
      end else begin
         unique case (phase_ff)
            PH_AMP, PH_NAMED: begin
               if ((phase_ff == PH_AMP) && (b == CH_HASH)) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_HASH;
               end else if (|ent_end) begin
                  kind     = KIND_DONE;
                  res_byte = ent_res;
               end else if (|ent_hit) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NAMED;
                  mask_in  = ent_hit;
               end
            end
            PH_HASH, PH_NUM_WS, PH_NUM_SIGN: begin
               if ((phase_ff == PH_HASH) && is_x) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_WS;
                  hex_in   = 1'b1;
               end else if ((phase_ff != PH_NUM_SIGN) && is_ws) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_WS;
               end else if ((phase_ff != PH_NUM_SIGN) && (b == CH_PLUS)) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_SIGN;
               end else if ((phase_ff != PH_NUM_SIGN) && (b == CH_MINUS)) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_SIGN;
                  neg_in   = 1'b1;
               end else if (dig_ok && hex_ff && (dig_val == 4'd0)) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_ZERO;
               end else if (dig_ok) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_DIG;
                  value_in = acc_val;
                  over_in  = over_ff | acc_over;
               end
            end
            PH_NUM_ZERO, PH_NUM_ZX, PH_NUM_DIG: begin
               if ((phase_ff == PH_NUM_ZERO) && hex_ff && is_x) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_ZX;
               end else if ((phase_ff != PH_NUM_ZX) && (b == CH_SEMI)) begin
                  kind     = KIND_DONE;
                  res_byte = num_res;
               end else if (dig_ok) begin
                  kind     = KIND_HOLD;
                  phase_in = PH_NUM_DIG;
                  value_in = acc_val;
                  over_in  = over_ff | acc_over;
               end
            end
            default: begin
               kind = KIND_FAIL;
            end
         endcase
      end
   end

   // Candidate registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         value_ff <= '0;
         hex_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         over_ff  <= 1'b0;
         mask_ff  <= '1;
      end else if (cmd.clear || (cmd.step && (kind == KIND_DONE))) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         value_ff <= '0;
         hex_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         over_ff  <= 1'b0;
         mask_ff  <= '1;
      end else if (cmd.reopen) begin
         phase_ff <= PH_AMP;
         count_ff <= CW'(1);
         value_ff <= '0;
         hex_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         over_ff  <= 1'b0;
         mask_ff  <= '1;
      end else if (cmd.step) begin
         phase_ff <= phase_in;
         count_ff <= count_ff + CW'(1);
         value_ff <= value_in;
         hex_ff   <= hex_in;
         neg_ff   <= neg_in;
         over_ff  <= over_in;
         mask_ff  <= mask_in;
      end
   end

   // Held byte memory: one write, one registered read
   assign wr_en   = (cmd.step && ((kind == KIND_OPEN) || (kind == KIND_HOLD))) || cmd.reopen;
   assign wr_addr = cmd.reopen ? '0 : count_ff[AW-1:0];
   assign wr_data = cmd.reopen ? CH_AMP : b;
   assign ptr_nx  = ptr_ff + AW'(1);
   assign rd_addr = cmd.rd_first ? '0 : ptr_nx;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= held_mem[rd_addr];
         ptr_ff     <= rd_addr;
      end
   end

   // Breaking byte kept across a flush
   always_ff @(posedge clock) begin
      if (cmd.save_tail) begin
         tail_byte_ff <= b;
         tail_last_ff <= req_tlast;
      end
   end

   // Output register
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      unique case (cmd.out_src)
         SRC_IN:   out_byte_in = b;
         SRC_RES:  out_byte_in = res_byte;
         SRC_MEM:  out_byte_in = rd_data_ff;
         SRC_TAIL: out_byte_in = tail_byte_ff;
         default:  out_byte_in = b;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_byte_ff     <= out_byte_in;
         out_run_last_ff <= cmd.out_run_last;
         out_str_last_ff <= cmd.out_str_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_run_last_ff;
   assign rsp_tlast  = out_str_last_ff;

   assign status.kind      = kind;
   assign status.in_last   = req_tlast;
   assign status.in_amp    = (b == CH_AMP);
   assign status.tail_last = tail_last_ff;
   assign status.more      = ((CW'(ptr_ff) + CW'(1)) < count_ff);
   assign status.out_free  = out_free;

endmodule

FILE: src/xed_ctrl.sv
module xed_ctrl import xed_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_RUN,
      S_FLUSH_RD,
      S_FLUSH_OUT,
      S_TAIL
   } state_type;

   // How a flush ends
   typedef enum logic [1:0] {
      END_STRING,   // string ended while held: last held byte closes it
      END_TAIL,     // breaking byte follows the held bytes
      END_REOPEN    // breaking byte was '&': it opens a new candidate
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic      accept;

   assign req_tready = (state_ff == S_RUN) && status.out_free;
   assign accept     = req_tvalid && req_tready;

   // Command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      mode_in  = mode_ff;
      unique case (state_ff)
         S_RUN: begin
            if (accept) begin
               unique case (status.kind)
                  KIND_COPY: begin
                     cmd.out_load     = 1'b1;
                     cmd.out_src      = SRC_IN;
                     cmd.out_run_last = 1'b1;
                     cmd.out_str_last = status.in_last;
                  end
                  KIND_OPEN: begin
                     if (status.in_last) begin
                        cmd.out_load     = 1'b1;
                        cmd.out_src      = SRC_IN;
                        cmd.out_run_last = 1'b1;
                        cmd.out_str_last = 1'b1;
                     end else begin
                        cmd.step = 1'b1;
                     end
                  end
                  KIND_DONE: begin
                     cmd.step         = 1'b1;
                     cmd.out_load     = 1'b1;
                     cmd.out_src      = SRC_RES;
                     cmd.out_run_last = 1'b1;
                     cmd.out_str_last = status.in_last;
                  end
                  KIND_HOLD: begin
                     cmd.step = 1'b1;
                     if (status.in_last) begin
                        state_in = S_FLUSH_RD;
                        mode_in  = END_STRING;
                     end
                  end
                  KIND_FAIL: begin
                     cmd.save_tail = 1'b1;
                     state_in      = S_FLUSH_RD;
                     mode_in       = (status.in_amp && !status.in_last) ? END_REOPEN : END_TAIL;
                  end
                  default: begin
                     state_in = S_RUN;
                  end
               endcase
            end
         end
         S_FLUSH_RD: begin
            cmd.rd_first = 1'b1;
            state_in     = S_FLUSH_OUT;
         end
         S_FLUSH_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_MEM;
               if (status.more) begin
                  cmd.rd_next = 1'b1;
               end else begin
                  unique case (mode_ff)
                     END_STRING: begin
                        cmd.out_run_last = 1'b1;
                        cmd.out_str_last = 1'b1;
                        cmd.clear        = 1'b1;
                        state_in         = S_RUN;
                     end
                     END_REOPEN: begin
                        cmd.out_run_last = 1'b1;
                        cmd.reopen       = 1'b1;
                        state_in         = S_RUN;
                     end
                     END_TAIL: begin
                        cmd.clear = 1'b1;
                        state_in  = S_TAIL;
                     end
                     default: begin
                        cmd.clear = 1'b1;
                        state_in  = S_RUN;
                     end
                  endcase
               end
            end
         end
         S_TAIL: begin
            if (status.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_src      = SRC_TAIL;
               cmd.out_run_last = 1'b1;
               cmd.out_str_last = status.tail_last;
               state_in         = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         mode_ff  <= END_TAIL;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

FILE: src/xml_entity_decoder_top.sv
// XML character reference decoder.
// Input channel req_*: one text byte per item, req_tlast marks the last byte of a string.
// Output channel rsp_*: decoded or copied bytes; rsp_tuser marks the last item caused
// by one input byte, rsp_tlast the last item of the string.
// Named entities (amp, lt, gt, quot, apos) and numeric references (&#dec; &#xhex;)
// become one byte; a broken or too long candidate is flushed as it came in.
// The result of an input item is loaded into the output register when the item is taken.
// Throughput: one input item per cycle while bytes are copied, held or resolved and the
// output register is free. An item that ends a candidate unresolved starts a flush:
// a memory read setup, then one held byte per cycle from the single read port while
// the output register is free, then the breaking byte when it is copied out after them.
// Input is not taken while a flush drains.
// Reset clears the candidate and the output register; held bytes are not cleared.
// If the receiver stalls, the output register holds its item and req_tready stays low
// until that item is taken.
module xml_entity_decoder_top import xed_pkg::*; #(
   parameter int MAX_PENDING = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tuser,    // [0] out_run_last
   output logic       rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   xed_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   xed_datapath #(
      .MAX_PENDING (MAX_PENDING)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/xed_checker.sv
`include "xml_entity_decoder_top_assert.svh"

module xed_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   logic       rsp_stall;
   logic [9:0] rsp_item;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_item  = {rsp_tlast, rsp_tuser, rsp_tdata};

   // A stalled output item stays put
   `XED_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_item))

   // The end of a string is also the end of its run
   `XED_ASSERT_NOW(a_str_ends_run, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

   // No input is taken while the output item is stalled
   `XED_ASSERT_NOW(a_no_take_on_stall, clock, reset, rsp_stall, !req_tready)

   // Output is empty right after reset
   `XED_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)

endmodule

bind xml_entity_decoder_top xed_checker u_xed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: tb/xml_entity_decoder_checker.sv
// Watches both channels of the entity decoder, predicts the decoded text
// for every accepted input byte and compares it with the output stream.
module xml_entity_decoder_checker #(
   parameter int MAX_PENDING = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [7:0] out_byte
   input  logic       rsp_tuser,    // [0] out_run_last
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending_count,
   output int         item_count,
   output int         result_count
);

   // Candidate progress
   typedef enum logic [3:0] {
      ST_IDLE  = 4'd0,
      ST_AMP   = 4'd1,
      ST_NAMED = 4'd2,
      ST_HASH  = 4'd3,
      ST_WS    = 4'd4,
      ST_SIGN  = 4'd5,
      ST_ZERO  = 4'd6,
      ST_ZX    = 4'd7,
      ST_DIG   = 4'd8,
      ST_DONE  = 4'd14,
      ST_FAIL  = 4'd15
   } cand_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       str_last;
   } text_item_type;

   localparam logic [7:0] CH_AMP   = "&";
   localparam logic [7:0] CH_HASH  = "#";
   localparam logic [7:0] CH_SEMI  = ";";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_QUEST = "?";
   localparam logic [7:0] CH_SPACE = " ";
   localparam int         NUM_NAMED = 5;

   // Predictor state
   cand_state_type cand_phase;
   logic [7:0]     held_text [MAX_PENDING];
   int             held_len;
   logic [7:0]     code_val;
   logic           code_hex;
   logic           code_neg;
   logic           code_over;

   text_item_type  step_out [$];
   text_item_type  expected_text [$];

   function automatic string entity_name(int e);
      case (e)
         0:       return "&amp;";
         1:       return "&lt;";
         2:       return "&gt;";
         3:       return "&quot;";
         default: return "&apos;";
      endcase
   endfunction

   function automatic logic [7:0] entity_char(int e);
      case (e)
         0:       return "&";
         1:       return "<";
         2:       return ">";
         3:       return "\"";
         default: return "'";
      endcase
   endfunction

   function automatic int digit_val(logic [7:0] b, logic hex);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (hex && b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (hex && b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   task automatic emit(input logic [7:0] b);
      text_item_type t;
      t.data     = b;
      t.run_last = 1'b0;
      t.str_last = 1'b0;
      step_out.insert(step_out.size(), t);
   endtask

   task automatic clear_cand();
      held_len   = 0;
      cand_phase = ST_IDLE;
      code_val   = '0;
      code_hex   = 1'b0;
      code_neg   = 1'b0;
      code_over  = 1'b0;
   endtask

   task automatic flush_held();
      for (int i = 0; i < held_len; i++) emit(held_text[i]);
      clear_cand();
   endtask

   // Value saturates at 127 and remembers that it overflowed
   task automatic accumulate(input int d);
      int v;
      v = int'(code_val) * (code_hex ? 16 : 10) + d;
      if (v > 127) begin
         code_over = 1'b1;
         v = 127;
      end
      code_val = v[7:0];
   endtask

   // Where byte b takes the held candidate
   task automatic next_phase(input logic [7:0] b, output cand_state_type nx,
                             output logic [7:0] res);
      int    d;
      logic  any;
      logic  same;
      string name;
      any = 1'b0;
      res = '0;
      nx  = ST_FAIL;
      if (cand_phase == ST_AMP && b == CH_HASH) begin
         nx = ST_HASH;
         return;
      end
      // named entities: some entry must still match the held prefix plus b
      if (cand_phase == ST_AMP || cand_phase == ST_NAMED) begin
         for (int e = 0; e < NUM_NAMED; e++) begin
            name = entity_name(e);
            if (held_len + 1 > name.len()) continue;
            same = 1'b1;
            for (int k = 0; k < held_len; k++)
               if (held_text[k] != name[k]) same = 1'b0;
            if (!same) continue;
            if (name[held_len] != b) continue;
            if (held_len + 1 == name.len()) begin
               res = entity_char(e);
               nx  = ST_DONE;
               return;
            end
            any = 1'b1;
         end
         nx = any ? ST_NAMED : ST_FAIL;
         return;
      end
      if (cand_phase == ST_HASH && (b == "x" || b == "X")) begin
         code_hex = 1'b1;
         nx = ST_WS;
         return;
      end
      // leading whitespace and sign
      if (cand_phase == ST_HASH || cand_phase == ST_WS) begin
         if (b == CH_SPACE || (b >= 8'd9 && b <= 8'd13)) begin
            nx = ST_WS;
            return;
         end
         if (b == CH_PLUS) begin
            nx = ST_SIGN;
            return;
         end
         if (b == CH_MINUS) begin
            code_neg = 1'b1;
            nx = ST_SIGN;
            return;
         end
      end
      // first digit; a hex zero may start an 0x prefix
      if (cand_phase == ST_HASH || cand_phase == ST_WS || cand_phase == ST_SIGN) begin
         d = digit_val(b, code_hex);
         if (d < 0) return;
         if (code_hex && d == 0) begin
            nx = ST_ZERO;
            return;
         end
         accumulate(d);
         nx = ST_DIG;
         return;
      end
      if (cand_phase == ST_ZERO && code_hex && (b == "x" || b == "X")) begin
         nx = ST_ZX;
         return;
      end
      if ((cand_phase == ST_ZERO || cand_phase == ST_DIG) && b == CH_SEMI) begin
         if (!code_neg && !code_over && code_val >= 8'd1) res = code_val;
         else res = CH_QUEST;
         nx = ST_DONE;
         return;
      end
      // further digits; after 0x a digit is required
      if (cand_phase == ST_ZERO || cand_phase == ST_ZX || cand_phase == ST_DIG) begin
         d = digit_val(b, code_hex);
         if (d < 0) return;
         accumulate(d);
         nx = ST_DIG;
      end
   endtask

   // A broken candidate is flushed and its breaking byte is taken again from idle
   task automatic take_byte(input logic [7:0] b);
      cand_state_type nx;
      logic [7:0]     r;
      for (int pass = 0; pass < 2; pass++) begin
         if (cand_phase == ST_IDLE) begin
            if (b == CH_AMP) begin
               held_text[0] = b;
               held_len     = 1;
               cand_phase   = ST_AMP;
            end else begin
               emit(b);
            end
            return;
         end
         if (held_len >= MAX_PENDING) begin
            flush_held();
            continue;
         end
         next_phase(b, nx, r);
         if (nx == ST_FAIL) begin
            flush_held();
            continue;
         end
         if (nx == ST_DONE) begin
            emit(r);
            clear_cand();
            return;
         end
         held_text[held_len] = b;
         held_len++;
         cand_phase = nx;
         return;
      end
   endtask

   // Expected output bytes for one input item
   task automatic decode_byte(input logic [7:0] b, input logic last);
      step_out.delete();
      take_byte(b);
      if (last && cand_phase != ST_IDLE) flush_held();
      if (step_out.size() > 0) begin
         step_out[step_out.size() - 1].run_last = 1'b1;
         step_out[step_out.size() - 1].str_last = last;
      end
      foreach (step_out[i]) expected_text.insert(expected_text.size(), step_out[i]);
   endtask

   // Results are matched before the new item is predicted
   always @(posedge clock) begin
      text_item_type want;
      if (reset) begin
         clear_cand();
         expected_text.delete();
         fail_count   <= 0;
         item_count   <= 0;
         result_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_text.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected output byte %02h (run_last %0b string_last %0b)",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser !== want.run_last ||
                   rsp_tlast !== want.str_last) begin
                  if (fail_count < 10) begin
                     $display("mismatch at output %0d: expected byte %02h run_last %0b %s %0b",
                              result_count, want.data, want.run_last, "string_last",
                              want.str_last);
                     $display("   got byte %02h run_last %0b string_last %0b",
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            item_count <= item_count + 1;
            decode_byte(req_tdata, req_tlast);
         end
      end
      pending_count <= expected_text.size();
   end

endmodule

FILE: tb/xml_entity_decoder_top_test.sv
// Stimulus and verdict for the entity decoder; checking lives in the checker.
module xml_entity_decoder_top_test;

   localparam int MAX_PENDING  = 16;
   localparam int RANDOM_ITEMS = 240;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 100;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] in_byte
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] out_byte
   logic       rsp_tuser;    // [0] out_run_last
   logic       rsp_tlast;

   int         fail_count;
   int         pending_count;
   int         item_count;
   int         result_count;

   logic       quiet;          // no idling on either side
   logic       rsp_hold_req;   // ask the receiver for one long hold-off
   logic [7:0] token_bytes [$];

   xml_entity_decoder_top #(.MAX_PENDING(MAX_PENDING)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   xml_entity_decoder_checker #(.MAX_PENDING(MAX_PENDING)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .item_count    (item_count),
      .result_count  (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Receiver: random ready stretches and stalls, one long hold on request
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
            n = quiet ? 0 : idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("no progress for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic end_string);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], end_string && i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Add one byte at the end of the token
   task automatic append_byte(input logic [7:0] b);
      token_bytes.insert(token_bytes.size(), b);
   endtask

   task automatic push_named();
      string s;
      case ($urandom_range(0, 4))
         0:       s = "&amp;";
         1:       s = "&lt;";
         2:       s = "&gt;";
         3:       s = "&quot;";
         default: s = "&apos;";
      endcase
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   // Well-formed numeric reference with random whitespace, sign, prefix and digits
   task automatic push_numeric();
      logic       hex;
      int         d;
      int         r;
      logic [7:0] ch;
      append_byte("&");
      append_byte("#");
      hex = 1'($urandom_range(0, 1));
      if (hex) append_byte($urandom_range(0, 1) ? "x" : "X");
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            r = $urandom_range(8, 13);
            append_byte(r == 8 ? 8'h20 : 8'(r));
         end
      end
      r = $urandom_range(0, 5);
      if (r == 0) append_byte("+");
      if (r == 1) append_byte("-");
      if (hex && $urandom_range(0, 3) == 0) begin
         append_byte("0");
         append_byte($urandom_range(0, 1) ? "x" : "X");
      end
      repeat ($urandom_range(1, 3)) begin
         d = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
         if (d < 10) ch = 8'("0" + d);
         else ch = 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
         append_byte(ch);
      end
      append_byte(";");
   endtask

   // One random token into token_bytes
   task automatic build_token();
      int r;
      int pos;
      token_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 25) begin
         // plain text, may hold stray '&'
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(1, 255)));
      end else if (r < 45) begin
         push_named();
      end else if (r < 75) begin
         push_numeric();
      end else if (r < 90) begin
         // broken reference: cut short and followed by a random byte
         if ($urandom_range(0, 1)) push_named();
         else push_numeric();
         pos = $urandom_range(1, token_bytes.size() - 1);
         token_bytes = token_bytes[0:pos-1];
         append_byte(8'($urandom_range(1, 255)));
      end else begin
         // too long for the holding buffer, or just fitting
         append_byte("&");
         append_byte("#");
         repeat ($urandom_range(11, 16)) append_byte("0");
         append_byte("7");
         append_byte(";");
      end
   endtask

   // Main stimulus
   initial begin
      int   sent;
      int   tokens;
      logic end_str;
      logic hold_done;
      logic pause_done;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      quiet        = 1'b0;
      rsp_hold_req = 1'b0;
      hold_done    = 1'b0;
      pause_done   = 1'b0;
      reset        = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cases
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_text("&amp;&lt;&gt;&quot;&apos;", 1'b1);
      send_text("&#65;&#x41;&#X4a;&# \t+9;&#\n-5;", 1'b1);
      send_text("&#200;&#0;&#x80;&#x0;", 1'b1);
      send_text("&#x0x41;&#x0X;&#0x41;", 1'b1);
      send_text("&ampx&&lt;", 1'b1);
      // longest candidate broken by a digit, then by the closing ';'
      send_text("&#00000000000000065;", 1'b0);
      send_text("&#00000000000007;", 1'b1);
      send_text("&quo", 1'b1);
      // full buffer flushed, then the breaking '&' copied out at string end
      send_text("&#00000000000000&", 1'b1);
      wait_drained();

      // random text
      sent   = 0;
      tokens = 0;
      while (sent < RANDOM_ITEMS) begin
         if (tokens % 12 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (!hold_done && sent >= 60) begin
            hold_done    = 1'b1;
            rsp_hold_req = 1'b1;
         end
         if (!pause_done && sent >= 160) begin
            pause_done = 1'b1;
            wait_drained();
         end
         build_token();
         end_str = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < token_bytes.size(); i++)
            send_byte(token_bytes[i],
                      i == token_bytes.size() - 1 ? end_str : ($urandom_range(0, 39) == 0));
         sent += token_bytes.size();
         tokens++;
      end
      send_byte("e", 1'b1);

      wait_drained();
      repeat (20) @(posedge clock);

      $display("decoder run: %0d input bytes, %0d output bytes checked", item_count,
               result_count);
      $display("named and numeric references, broken and overlong candidates, stalls");
      if (pending_count != 0)
         $display("%0d expected output bytes never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
